@@ sv/tks_pkg.sv @@
package tks_pkg;

	localparam int KEEP_W = 5;
	localparam int DIST_W = 32;
	localparam int TAG_W = 64;

	// Keep limit after reset.
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;    // an input transaction completes
		logic insert;  // that transaction carries a hit
		logic pop;     // the head entry leaves on the result channel
	} tks_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;    // the head entry is the final result of the set
	} tks_sts_t;

endpackage

@@ sv/tks_if.sv @@
interface tks_hit_if
	import tks_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              hit_present;
	logic [DIST_W-1:0] hit_distance;
	logic [TAG_W-1:0]  hit_tag;
	logic              end_of_set;

	modport source (
		output valid, hit_present, hit_distance, hit_tag, end_of_set,
		input  ready
	);
	modport sink (
		input  valid, hit_present, hit_distance, hit_tag, end_of_set,
		output ready
	);
endinterface

interface tks_res_if
	import tks_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              out_present;
	logic [DIST_W-1:0] out_distance;
	logic [TAG_W-1:0]  out_tag;
	logic              out_last;

	modport source (
		output valid, out_present, out_distance, out_tag, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_present, out_distance, out_tag, out_last,
		output ready
	);
endinterface

@@ sv/tks_datapath.sv @@
module tks_datapath
	import tks_pkg::*;
#(
	parameter int MAX_KEEP = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [KEEP_W-1:0] cfg_wdata,
	input  tks_cmd_t          cmd,
	output tks_sts_t          sts,
	input  logic [DIST_W-1:0] hit_distance,
	input  logic [TAG_W-1:0]  hit_tag,
	output logic              out_present,
	output logic [DIST_W-1:0] out_distance,
	output logic [TAG_W-1:0]  out_tag,
	output logic              out_last
);

	localparam int CW = $clog2(MAX_KEEP + 1);

	logic [KEEP_W-1:0] keep_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     limit;
	logic [CW-1:0]     eff_cnt;
	logic [CW-1:0]     next_cnt;
	logic [DIST_W-1:0] dist_q [MAX_KEEP];
	logic [TAG_W-1:0]  tag_q [MAX_KEEP];
	logic [DIST_W-1:0] prv_d [MAX_KEEP];
	logic [TAG_W-1:0]  prv_t [MAX_KEEP];
	logic [DIST_W-1:0] nxt_d [MAX_KEEP];
	logic [TAG_W-1:0]  nxt_t [MAX_KEEP];
	logic [MAX_KEEP-1:0] valid_m;
	logic [MAX_KEEP-1:0] le;
	logic [MAX_KEEP-1:0] prv_le;
	logic              all_le;
	logic              blocked;
	logic              do_ins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			keep_q <= cfg_wdata;
		end
	end

	assign limit = (32'(keep_q) > 32'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(keep_q);
	// A lowered limit cuts the list at the next transaction.
	assign eff_cnt = (count_q > limit) ? limit : count_q;

	// Each cell compares its own entry against the incoming distance.
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cmp
		assign valid_m[i] = CW'(i) < eff_cnt;
		assign le[i] = valid_m[i] && (dist_q[i] <= hit_distance);
		if (i == 0) begin : g_first
			assign prv_le[i] = 1'b1;
			assign prv_d[i] = hit_distance;
			assign prv_t[i] = hit_tag;
		end else begin : g_rest
			assign prv_le[i] = le[i-1];
			assign prv_d[i] = dist_q[i-1];
			assign prv_t[i] = tag_q[i-1];
		end
		if (i == MAX_KEEP - 1) begin : g_tail
			assign nxt_d[i] = dist_q[i];
			assign nxt_t[i] = tag_q[i];
		end else begin : g_body
			assign nxt_d[i] = dist_q[i+1];
			assign nxt_t[i] = tag_q[i+1];
		end
	end

	// A full list whose entries are all at or below the new hit rejects it.
	assign all_le = &(le | ~valid_m);
	assign blocked = (limit == '0) || ((eff_cnt == limit) && all_le);
	assign do_ins = cmd.insert && !blocked;

	always_comb begin
		next_cnt = eff_cnt;
		if (do_ins && (eff_cnt != limit)) begin
			next_cnt = eff_cnt + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.take) begin
			count_q <= next_cnt;
		end else if (cmd.pop && (count_q != '0)) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Cells at or below the hit hold; the first larger one loads the hit and
	// the rest shift down by one. Popping shifts the list toward the head.
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins && !le[i]) begin
				if (prv_le[i]) begin
					dist_q[i] <= hit_distance;
					tag_q[i] <= hit_tag;
				end else begin
					dist_q[i] <= prv_d[i];
					tag_q[i] <= prv_t[i];
				end
			end else if (cmd.pop) begin
				dist_q[i] <= nxt_d[i];
				tag_q[i] <= nxt_t[i];
			end
		end
	end

	assign out_present = count_q != '0;
	assign out_distance = out_present ? dist_q[0] : '0;
	assign out_tag = out_present ? tag_q[0] : '0;
	assign out_last = count_q <= CW'(1);
	assign sts.last = out_last;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(MAX_KEEP))
		else $error("kept count exceeds list depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && !cmd.take && (count_q > CW'(1))) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not retire exactly one entry");

	for (genvar i = 1; i < MAX_KEEP; i++) begin : g_sorted
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(CW'(i) < count_q) |-> (dist_q[i-1] <= dist_q[i]))
			else $error("kept list out of order");
	end
`endif

endmodule

@@ sv/tks_ctrl.sv @@
module tks_ctrl
	import tks_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_present,
	input  logic     in_end,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  tks_sts_t sts,
	output tks_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic accept;

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_EMIT;
	assign accept = in_valid && in_ready;

	assign cmd.take = accept;
	assign cmd.insert = accept && in_present;
	assign cmd.pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.pop && sts.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_end) |=> out_valid)
		else $error("end of set did not start emission");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && sts.last) |=> in_ready)
		else $error("final result did not return to accepting input");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take && cmd.pop))
		else $error("input and output transactions overlapped");
`endif

endmodule

@@ sv/top_k_smallest_merge.sv @@
// Top-k smallest-distance merge.
// Hits arrive on hit_in, one transaction per cycle while ready is high. Each
// carries a distance (compared as an unsigned 32-bit pattern) and a 64-bit
// tag. The block keeps up to keep_count hits, sorted ascending, in a chain of
// cells that all compare against the new hit at once, so a hit is inserted
// in the cycle it is accepted. Equal distances keep arrival order.
// A transaction with end_of_set set closes the set (after its own hit, if
// any). From the next cycle the kept hits leave on res_out in ascending
// order, one per cycle, out_last on the final one; an empty set gives one
// result with out_present low. While results are pending hit_in is not ready,
// so the next set waits for the last result; the output rate is set by the
// head cell of the chain, which shifts once per result.
// When the receiver stalls, the head result holds and nothing moves.
// keep_count is written through cfg_we / cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce. Values above
// MAX_KEEP act as MAX_KEEP, zero keeps nothing. Reset empties the list,
// returns to accepting input and sets keep_count to 16.
module top_k_smallest_merge
	import tks_pkg::*;
#(
	parameter int MAX_KEEP = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [KEEP_W-1:0] cfg_wdata,
	tks_hit_if.sink           hit_in,
	tks_res_if.source         res_out
);

	tks_cmd_t cmd;
	tks_sts_t sts;

	// The controller owns both handshakes; the datapath holds the list.
	tks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hit_in.valid),
		.in_present(hit_in.hit_present),
		.in_end    (hit_in.end_of_set),
		.in_ready  (hit_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Results come straight from the head cell and the count register.
	tks_datapath #(
		.MAX_KEEP(MAX_KEEP)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.sts         (sts),
		.hit_distance(hit_in.hit_distance),
		.hit_tag     (hit_in.hit_tag),
		.out_present (res_out.out_present),
		.out_distance(res_out.out_distance),
		.out_tag     (res_out.out_tag),
		.out_last    (res_out.out_last)
	);

endmodule
